@@ rtl/core/beacon_element_parser_unit_macros.svh @@
// Assertion helpers for the beacon element parser
`ifndef BEACON_ELEMENT_PARSER_UNIT_MACROS_SVH
`define BEACON_ELEMENT_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BEP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bep_pkg.sv @@
package bep_pkg;

  // Walk phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TAG    = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  // Element IDs
  localparam logic [7:0] EID_SSID      = 8'd0;
  localparam logic [7:0] EID_RATES     = 8'd1;
  localparam logic [7:0] EID_DS        = 8'd3;
  localparam logic [7:0] EID_HT        = 8'd45;
  localparam logic [7:0] EID_RSN       = 8'd48;
  localparam logic [7:0] EID_EXT_RATES = 8'd50;
  localparam logic [7:0] EID_VHT       = 8'd191;
  localparam logic [7:0] EID_VENDOR    = 8'd221;

  // Encryption classes
  localparam logic [1:0] ENC_OPEN = 2'd0;
  localparam logic [1:0] ENC_WEP  = 2'd1;
  localparam logic [1:0] ENC_WPA  = 2'd2;
  localparam logic [1:0] ENC_WPA2 = 2'd3;

  // Header byte positions
  localparam logic [10:0] POS_FRAME_CTRL = 11'd0;
  localparam logic [10:0] POS_CAP_LOW    = 11'd34;
  localparam logic [10:0] POS_HDR_END    = 11'd35;
  localparam logic [10:0] POS_MAX        = 11'd2047;

  // Frame control and capability masks
  localparam logic [7:0] FC_TYPE_MASK  = 8'hFC;
  localparam logic [7:0] FC_BEACON     = 8'h80;
  localparam logic [7:0] LEGACY_MASK   = 8'h7F;
  localparam logic [7:0] VHT_NSS_MASK  = 8'h0C;

  // Element limits
  localparam logic [7:0] SSID_MAX        = 8'd32;
  localparam logic [7:0] PRINT_LOW       = 8'd32;
  localparam logic [7:0] PRINT_HIGH      = 8'd126;
  localparam logic [7:0] VENDOR_MIN_LEN  = 8'd4;
  localparam logic [7:0] HT_MIN_LEN      = 8'd26;
  localparam logic [7:0] VHT_MIN_LEN     = 8'd12;
  localparam logic [5:0] ENTRY_MAX       = 6'd63;

  // VHT rates in Mbps
  localparam logic [10:0] VHT_R292  = 11'd292;
  localparam logic [10:0] VHT_R433  = 11'd433;
  localparam logic [10:0] VHT_R585  = 11'd585;
  localparam logic [10:0] VHT_R866  = 11'd866;
  localparam logic [10:0] VHT_R1733 = 11'd1733;

  // Divide by five: multiply by 2^15/5 rounded up, then shift
  localparam logic [12:0] RECIP5       = 13'd6554;
  localparam int          RECIP5_SHIFT = 15;

  // HT rates by MCS bit, 20 MHz and 40 MHz, one and two spatial streams
  localparam logic [7:0] HT1_20 [0:7] = '{8'd7, 8'd13, 8'd20, 8'd26,
                                          8'd33, 8'd39, 8'd46, 8'd52};
  localparam logic [7:0] HT1_40 [0:7] = '{8'd14, 8'd27, 8'd41, 8'd55,
                                          8'd68, 8'd82, 8'd96, 8'd109};
  localparam logic [7:0] HT2_20 [0:7] = '{8'd13, 8'd26, 8'd39, 8'd52,
                                          8'd65, 8'd78, 8'd91, 8'd104};
  localparam logic [7:0] HT2_40 [0:7] = '{8'd27, 8'd55, 8'd82, 8'd109,
                                          8'd137, 8'd164, 8'd191, 8'd218};

  // One element as it completes
  typedef struct packed {
    logic       commit;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] b0;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [6:0] lmax;
    logic [5:0] lcount;
    logic       ok;
  } bep_elem_t;

  // One processed byte as seen by the summary
  typedef struct packed {
    logic      go;
    logic      last_byte;
    logic      beacon;
    logic      privacy;
    bep_elem_t elem;
  } bep_step_t;

  // Frame summary before output formatting
  typedef struct packed {
    logic        beacon;
    logic        privacy;
    logic [1:0]  sec;
    logic [7:0]  channel;
    logic [10:0] best;
    logic [5:0]  ssid_len;
    logic        ssid_ok;
  } bep_raw_t;

  // WPA vendor OUI and type, byte by byte
  function automatic logic [7:0] wpa_oui_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h50;
      2'd2:    v = 8'hF2;
      default: v = 8'h01;
    endcase
    return v;
  endfunction

  // Count set bits of one MCS byte
  function automatic logic [3:0] pop8(input logic [7:0] bits);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, bits[i]};
    end
    return n;
  endfunction

  // Highest rate of one HT stream byte, zero when no bit is set
  function automatic logic [7:0] ht_stream_max(input logic [7:0] bits,
                                               input logic two_ss,
                                               input logic wide);
    logic [2:0] k;
    logic [7:0] r;
    k = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) k = 3'(i);
    end
    case ({two_ss, wide})
      2'b00:   r = HT1_20[k];
      2'b01:   r = HT1_40[k];
      2'b10:   r = HT2_20[k];
      default: r = HT2_40[k];
    endcase
    if (bits == 8'd0) r = 8'd0;
    return r;
  endfunction

endpackage

@@ rtl/core/bep_walk.sv @@
module bep_walk #(
  parameter int WINDOW_BYTES    = 1024,
  parameter int LEGACY_RATE_CAP = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [7:0]         frame_byte,
  input  logic               last_byte,
  input  logic [5:0]         rate_entries,
  output bep_pkg::bep_step_t step
);

  localparam logic [11:0] WIN = 12'(WINDOW_BYTES);
  localparam logic [6:0]  CAP = 7'(LEGACY_RATE_CAP);

  logic [10:0] pos_r, pos_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        stopped_r, stopped_nxt;
  logic        beacon_r, beacon_nxt;
  logic        privacy_r, privacy_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [7:0]  b0_r, b0_nxt;
  logic [7:0]  b3_r, b3_nxt;
  logic [7:0]  b4_r, b4_nxt;
  logic [6:0]  lmax_r, lmax_nxt;
  logic [5:0]  lcount_r, lcount_nxt;
  logic        ok_r, ok_nxt;
  logic        commit;
  logic [11:0] pos_ext;
  logic [7:0]  off_inc;
  logic [7:0]  leg_sum;
  logic [6:0]  leg_rate;

  assign pos_ext  = {1'b0, pos_r};
  assign off_inc  = off_r + 8'd1;
  assign leg_sum  = {1'b0, frame_byte[6:0] & bep_pkg::LEGACY_MASK[6:0]} + 8'd1;
  assign leg_rate = leg_sum[7:1];

  // Walk header, tags, lengths and element bodies
  always_comb begin
    pos_nxt     = (pos_r < bep_pkg::POS_MAX) ? pos_r + 11'd1 : pos_r;
    phase_nxt   = phase_r;
    stopped_nxt = stopped_r;
    beacon_nxt  = beacon_r;
    privacy_nxt = privacy_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    off_nxt     = off_r;
    b0_nxt      = b0_r;
    b3_nxt      = b3_r;
    b4_nxt      = b4_r;
    lmax_nxt    = lmax_r;
    lcount_nxt  = lcount_r;
    ok_nxt      = ok_r;
    commit      = 1'b0;
    if (phase_r == bep_pkg::PH_HEADER) begin
      if (pos_r == bep_pkg::POS_FRAME_CTRL) begin
        beacon_nxt = (frame_byte & bep_pkg::FC_TYPE_MASK) == bep_pkg::FC_BEACON;
      end
      if (pos_r == bep_pkg::POS_CAP_LOW) privacy_nxt = frame_byte[4];
      if (pos_r == bep_pkg::POS_HDR_END) phase_nxt = bep_pkg::PH_TAG;
    end else if (!stopped_r) begin
      case (phase_r)
        bep_pkg::PH_TAG: begin
          id_nxt    = frame_byte;
          phase_nxt = bep_pkg::PH_LENGTH;
        end
        bep_pkg::PH_LENGTH: begin
          if (frame_byte == 8'd0 || pos_ext + 12'd1 + {4'd0, frame_byte} > WIN) begin
            stopped_nxt = 1'b1;
          end else begin
            len_nxt    = frame_byte;
            off_nxt    = 8'd0;
            b0_nxt     = 8'd0;
            b3_nxt     = 8'd0;
            b4_nxt     = 8'd0;
            lmax_nxt   = 7'd0;
            lcount_nxt = 6'd0;
            ok_nxt     = 1'b1;
            phase_nxt  = bep_pkg::PH_DATA;
          end
        end
        default: begin
          case (id_r)
            bep_pkg::EID_SSID: begin
              if (off_r < bep_pkg::SSID_MAX &&
                  (frame_byte < bep_pkg::PRINT_LOW || frame_byte > bep_pkg::PRINT_HIGH)) begin
                ok_nxt = 1'b0;
              end
            end
            bep_pkg::EID_RATES, bep_pkg::EID_EXT_RATES: begin
              if ({1'b0, rate_entries} + {1'b0, lcount_r} < CAP) begin
                if (leg_rate > lmax_r) lmax_nxt = leg_rate;
                lcount_nxt = lcount_r + 6'd1;
              end
            end
            bep_pkg::EID_VENDOR: begin
              if (off_r < 8'd4 && frame_byte != bep_pkg::wpa_oui_byte(off_r[1:0])) begin
                ok_nxt = 1'b0;
              end
            end
            default: begin
              if (off_r == 8'd0) b0_nxt = frame_byte;
              else if (off_r == 8'd3) b3_nxt = frame_byte;
              else if (off_r == 8'd4) b4_nxt = frame_byte;
            end
          endcase
          off_nxt = off_inc;
          if (off_inc == len_r) begin
            commit    = 1'b1;
            phase_nxt = bep_pkg::PH_TAG;
          end
        end
      endcase
      // Stop at the window edge
      if (pos_ext + 12'd1 >= WIN) stopped_nxt = 1'b1;
    end
  end

  // Hand the byte's effect to the summary
  always_comb begin
    step.go          = go;
    step.last_byte   = last_byte;
    step.beacon      = beacon_nxt;
    step.privacy     = privacy_nxt;
    step.elem.commit = commit;
    step.elem.id     = id_r;
    step.elem.len    = len_r;
    step.elem.b0     = b0_nxt;
    step.elem.b3     = b3_nxt;
    step.elem.b4     = b4_nxt;
    step.elem.lmax   = lmax_nxt;
    step.elem.lcount = lcount_nxt;
    step.elem.ok     = ok_nxt;
  end

  // Control state; the last byte of a frame returns it to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 11'd0;
      phase_r   <= bep_pkg::PH_HEADER;
      stopped_r <= 1'b0;
      beacon_r  <= 1'b0;
      privacy_r <= 1'b0;
    end else if (go) begin
      if (last_byte) begin
        pos_r     <= 11'd0;
        phase_r   <= bep_pkg::PH_HEADER;
        stopped_r <= 1'b0;
        beacon_r  <= 1'b0;
        privacy_r <= 1'b0;
      end else begin
        pos_r     <= pos_nxt;
        phase_r   <= phase_nxt;
        stopped_r <= stopped_nxt;
        beacon_r  <= beacon_nxt;
        privacy_r <= privacy_nxt;
      end
    end
  end

  // Element payload, only read inside an element
  always_ff @(posedge clk) begin
    if (go) begin
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      off_r    <= off_nxt;
      b0_r     <= b0_nxt;
      b3_r     <= b3_nxt;
      b4_r     <= b4_nxt;
      lmax_r   <= lmax_nxt;
      lcount_r <= lcount_nxt;
      ok_r     <= ok_nxt;
    end
  end

endmodule

@@ rtl/core/bep_summary.sv @@
module bep_summary (
  input  logic               clk,
  input  logic               rst_n,
  input  bep_pkg::bep_step_t step,
  output logic [5:0]         rate_entries,
  output logic               res_valid,
  output bep_pkg::bep_raw_t  res
);

  logic [1:0]  sec_r, sec_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic [10:0] best_r, best_nxt;
  logic [5:0]  entries_r, entries_nxt;
  logic [5:0]  ssid_len_r, ssid_len_nxt;
  logic        ssid_ok_r, ssid_ok_nxt;
  logic [10:0] cand_rate;
  logic [5:0]  cand_n;
  logic [6:0]  entries_sum;
  logic        wide;
  logic [7:0]  ht_m3, ht_m4, ht_max;
  logic [4:0]  ht_n;
  logic [2:0]  vht_n;
  logic [10:0] vht_max;

  assign wide   = step.elem.b0[1];
  assign ht_m3  = bep_pkg::ht_stream_max(step.elem.b3, 1'b0, wide);
  assign ht_m4  = bep_pkg::ht_stream_max(step.elem.b4, 1'b1, wide);
  assign ht_max = (ht_m4 > ht_m3) ? ht_m4 : ht_m3;
  assign ht_n   = {1'b0, bep_pkg::pop8(step.elem.b3)} + {1'b0, bep_pkg::pop8(step.elem.b4)};

  // VHT rate set from the supported width and MCS map
  always_comb begin
    vht_n   = 3'd0;
    vht_max = 11'd0;
    if (step.elem.b0[2]) begin
      vht_n   = 3'd2;
      vht_max = bep_pkg::VHT_R433;
      if ((step.elem.b4 & bep_pkg::VHT_NSS_MASK) != bep_pkg::VHT_NSS_MASK) begin
        vht_n   = 3'd4;
        vht_max = bep_pkg::VHT_R866;
      end
    end
    if (step.elem.b0[3]) begin
      vht_n   = vht_n + 3'd2;
      vht_max = bep_pkg::VHT_R1733;
    end
  end

  // Fold a completed element into the frame summary
  always_comb begin
    sec_nxt      = sec_r;
    chan_nxt     = chan_r;
    ssid_len_nxt = ssid_len_r;
    ssid_ok_nxt  = ssid_ok_r;
    cand_rate    = 11'd0;
    cand_n       = 6'd0;
    if (step.go && step.elem.commit) begin
      case (step.elem.id)
        bep_pkg::EID_SSID: begin
          ssid_len_nxt = (step.elem.len > bep_pkg::SSID_MAX) ?
                         6'(bep_pkg::SSID_MAX) : step.elem.len[5:0];
          ssid_ok_nxt  = step.elem.ok;
        end
        bep_pkg::EID_RATES, bep_pkg::EID_EXT_RATES: begin
          cand_rate = {4'd0, step.elem.lmax};
          cand_n    = step.elem.lcount;
        end
        bep_pkg::EID_DS: chan_nxt = step.elem.b0;
        bep_pkg::EID_RSN: sec_nxt = bep_pkg::ENC_WPA2;
        bep_pkg::EID_VENDOR: begin
          if (step.elem.len >= bep_pkg::VENDOR_MIN_LEN && step.elem.ok) begin
            sec_nxt = bep_pkg::ENC_WPA;
          end
        end
        bep_pkg::EID_HT: begin
          if (step.elem.len >= bep_pkg::HT_MIN_LEN) begin
            cand_rate = {3'd0, ht_max};
            cand_n    = wide ? {ht_n, 1'b0} : {1'b0, ht_n};
          end
        end
        bep_pkg::EID_VHT: begin
          if (step.elem.len >= bep_pkg::VHT_MIN_LEN) begin
            cand_rate = vht_max;
            cand_n    = {3'd0, vht_n};
          end
        end
        default: begin
        end
      endcase
    end
    best_nxt    = (cand_rate > best_r) ? cand_rate : best_r;
    entries_sum = {1'b0, entries_r} + {1'b0, cand_n};
    entries_nxt = (entries_sum > {1'b0, bep_pkg::ENTRY_MAX}) ?
                  bep_pkg::ENTRY_MAX : entries_sum[5:0];
  end

  assign rate_entries = entries_r;
  assign res_valid    = step.go && step.last_byte;

  // Summary of the frame including this byte
  always_comb begin
    res.beacon   = step.beacon;
    res.privacy  = step.privacy;
    res.sec      = sec_nxt;
    res.channel  = chan_nxt;
    res.best     = best_nxt;
    res.ssid_len = ssid_len_nxt;
    res.ssid_ok  = ssid_ok_nxt;
  end

  // Hold the summary; clear it after each frame
  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      sec_r      <= bep_pkg::ENC_OPEN;
      chan_r     <= 8'd0;
      best_r     <= 11'd0;
      entries_r  <= 6'd0;
      ssid_len_r <= 6'd0;
      ssid_ok_r  <= 1'b1;
    end else if (step.go) begin
      sec_r      <= sec_nxt;
      chan_r     <= chan_nxt;
      best_r     <= best_nxt;
      entries_r  <= entries_nxt;
      ssid_len_r <= ssid_len_nxt;
      ssid_ok_r  <= ssid_ok_nxt;
    end
  end

endmodule

@@ rtl/core/bep_result.sv @@
module bep_result (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  bep_pkg::bep_raw_t res,
  output logic              res_free,
  output logic              hold_valid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_is_beacon,
  output logic [1:0]        out_enc_mode,
  output logic [7:0]        out_channel,
  output logic [10:0]       out_max_rate_mbps,
  output logic [5:0]        out_ssid_length,
  output logic              out_ssid_printable
);

  bep_pkg::bep_raw_t hold_r;
  logic              hold_valid_r;
  logic              out_valid_r;
  logic              hold_move;
  logic [11:0]       rate_bias;
  logic [24:0]       rate_prod;
  logic [8:0]        rate_q;
  logic [10:0]       rate_round;
  logic [1:0]        enc;

  assign hold_move  = hold_valid_r && (!out_valid_r || !out_stall);
  assign res_free   = !hold_valid_r || hold_move;
  assign hold_valid = hold_valid_r;
  assign out_valid  = out_valid_r;

  // Round the rate to a multiple of five
  assign rate_bias  = {1'b0, hold_r.best} + 12'd2;
  assign rate_prod  = {13'd0, rate_bias} * {12'd0, bep_pkg::RECIP5};
  assign rate_q     = rate_prod[bep_pkg::RECIP5_SHIFT +: 9];
  assign rate_round = {rate_q, 2'b00} + {2'b00, rate_q};

  // Fall back to WEP or open without a WPA or RSN element
  assign enc = (hold_r.sec != bep_pkg::ENC_OPEN) ? hold_r.sec :
               (hold_r.privacy ? bep_pkg::ENC_WEP : bep_pkg::ENC_OPEN);

  // Valid flags of the holding stage and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (res_valid) hold_valid_r <= 1'b1;
      else if (hold_move) hold_valid_r <= 1'b0;
      if (hold_move) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Capture the frame summary
  always_ff @(posedge clk) begin
    if (res_valid) hold_r <= res;
  end

  // Load the output register; a non-beacon shows all zeros
  always_ff @(posedge clk) begin
    if (hold_move) begin
      out_is_beacon      <= hold_r.beacon;
      out_enc_mode       <= hold_r.beacon ? enc : bep_pkg::ENC_OPEN;
      out_channel        <= hold_r.beacon ? hold_r.channel : 8'd0;
      out_max_rate_mbps  <= hold_r.beacon ? rate_round : 11'd0;
      out_ssid_length    <= hold_r.beacon ? hold_r.ssid_len : 6'd0;
      out_ssid_printable <= hold_r.beacon && hold_r.ssid_ok;
    end
  end

endmodule

@@ rtl/core/beacon_element_parser_unit.sv @@
// A frame's summary goes to the result holding stage, then to the output register.
// Throughput: one frame byte per cycle, but in_stall holds the input while a last byte waits
//   and the holding stage is full; the last byte waits only while the output also stalls.
// Reset: synchronous active-low rst_n clears the walk, the frame summary and all valid flags.
//   The last byte of each frame also returns the per-frame state to its reset value.
module beacon_element_parser_unit #(
  parameter int WINDOW_BYTES    = 1024,
  parameter int LEGACY_RATE_CAP = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_beacon,
  output logic [1:0]  out_enc_mode,
  output logic [7:0]  out_channel,
  output logic [10:0] out_max_rate_mbps,
  output logic [5:0]  out_ssid_length,
  output logic        out_ssid_printable
);

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_last_r;
  logic               s1_go;
  logic               in_xfer;
  logic               res_free;
  logic               hold_valid;
  logic [5:0]         rate_entries;
  logic               res_valid;
  bep_pkg::bep_step_t step;
  bep_pkg::bep_raw_t  res;

  // A last byte may only proceed when the result stage can take its summary
  assign s1_go    = s1_valid_r && (!s1_last_r || res_free);
  assign in_stall = s1_valid_r && s1_last_r && hold_valid;
  assign in_xfer  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_frame_byte;
      s1_last_r <= in_last_byte;
    end
  end

  bep_walk #(
    .WINDOW_BYTES    (WINDOW_BYTES),
    .LEGACY_RATE_CAP (LEGACY_RATE_CAP)
  ) u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (s1_go),
    .frame_byte   (s1_byte_r),
    .last_byte    (s1_last_r),
    .rate_entries (rate_entries),
    .step         (step)
  );

  bep_summary u_summary (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rate_entries (rate_entries),
    .res_valid    (res_valid),
    .res          (res)
  );

  bep_result u_result (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (res_valid),
    .res                (res),
    .res_free           (res_free),
    .hold_valid         (hold_valid),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_beacon      (out_is_beacon),
    .out_enc_mode       (out_enc_mode),
    .out_channel        (out_channel),
    .out_max_rate_mbps  (out_max_rate_mbps),
    .out_ssid_length    (out_ssid_length),
    .out_ssid_printable (out_ssid_printable)
  );

`include "beacon_element_parser_unit_macros.svh"

  `BEP_ASSERT_NEXT(a_last_byte_captured, s1_go && s1_last_r, hold_valid, "frame summary lost")
  `BEP_ASSERT_NOW(a_non_beacon_zero, out_valid && !out_is_beacon, out_enc_mode == 2'd0 && out_channel == 8'd0 && out_max_rate_mbps == 11'd0 && out_ssid_length == 6'd0 && !out_ssid_printable, "non-beacon result not cleared")
  `BEP_ASSERT_NOW(a_ssid_clipped, out_valid, out_ssid_length <= 6'd32, "SSID length above clip")

endmodule

@@ verif/beacon_summary_checker.sv @@
`timescale 1ns / 100ps

module beacon_summary_checker
  import bep_pkg::*;
#(
  parameter int WINDOW_BYTES    = 1024,
  parameter int LEGACY_RATE_CAP = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_is_beacon,
  input  logic [1:0]  out_enc_mode,
  input  logic [7:0]  out_channel,
  input  logic [10:0] out_max_rate_mbps,
  input  logic [5:0]  out_ssid_length,
  input  logic        out_ssid_printable,
  output int          fail_count,
  output int          pending_results,
  output int          results_checked
);

  // Vendor OUI and type that mark a WPA element, first byte in the top lane
  localparam logic [31:0] WPA_TAG = 32'h0050F201;
  localparam int unsigned HT_STEP_ONE = 13;
  localparam int unsigned HT_STEP_TWO = 26;
  localparam int          MAX_PRINTED = 40;

  typedef struct packed {
    logic        beacon;
    logic [1:0]  enc;
    logic [7:0]  chan;
    logic [10:0] rate;
    logic [5:0]  ssid_len;
    logic        ssid_ok;
  } frame_summary_t;

  frame_summary_t summary_q[$];

  // Per-frame walk state
  int unsigned byte_pos;
  logic [1:0]  walk_phase;
  logic [7:0]  elem_id;
  logic [7:0]  elem_len;
  logic [7:0]  elem_off;
  logic        beacon_seen;
  logic        privacy_bit;
  logic        walk_done;
  logic [1:0]  sec_class;
  logic [7:0]  chan_num;
  int unsigned top_rate;
  int unsigned rate_count;
  logic [5:0]  ssid_kept;
  logic        ssid_clean;

  // Values gathered from the element in flight
  logic [7:0]  pend_b0;
  logic [7:0]  pend_b3;
  logic [7:0]  pend_b4;
  int unsigned pend_lmax;
  int unsigned pend_count;
  logic        pend_ok;

  task automatic clear_pending();
    pend_b0    = '0;
    pend_b3    = '0;
    pend_b4    = '0;
    pend_lmax  = 0;
    pend_count = 0;
    pend_ok    = 1'b0;
  endtask

  task automatic clear_frame();
    byte_pos    = 0;
    walk_phase  = PH_HEADER;
    elem_id     = '0;
    elem_len    = '0;
    elem_off    = '0;
    beacon_seen = 1'b0;
    privacy_bit = 1'b0;
    walk_done   = 1'b0;
    sec_class   = ENC_OPEN;
    chan_num    = '0;
    top_rate    = 0;
    rate_count  = 0;
    ssid_kept   = '0;
    ssid_clean  = 1'b1;
    clear_pending();
  endtask

  task automatic report_mismatch(input string what, input logic [10:0] got_v,
                                 input logic [10:0] want_v);
    if (fail_count < MAX_PRINTED) begin
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got_v, want_v);
    end
    fail_count++;
  endtask

  // One rate entry: track the best and count it, saturating
  task automatic note_rate(input int unsigned r);
    if (r > top_rate) top_rate = r;
    if (rate_count < ENTRY_MAX) rate_count++;
  endtask

  // HT MCS bits; h is in half-Mbps units, 40 MHz is 2.1 times rounded half up
  task automatic add_ht_rates(input logic [7:0] bits, input int unsigned step,
                              input logic wide);
    int unsigned h;
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) begin
        h = step * (i + 1);
        note_rate((h + 1) >> 1);
        if (wide) note_rate((21 * h + 10) / 20);
      end
    end
  endtask

  task automatic take_element_byte(input logic [7:0] b);
    int unsigned r;
    case (elem_id)
      EID_SSID: begin
        if (elem_off < SSID_MAX && (b < PRINT_LOW || b > PRINT_HIGH)) pend_ok = 1'b0;
      end
      EID_RATES, EID_EXT_RATES: begin
        // Legacy rates enter only below the cap
        if (rate_count + pend_count < LEGACY_RATE_CAP) begin
          r = ((b & LEGACY_MASK) + 1) >> 1;
          if (r > pend_lmax) pend_lmax = r;
          pend_count++;
        end
      end
      EID_VENDOR: begin
        if (elem_off < VENDOR_MIN_LEN && b != WPA_TAG[31 - 8 * int'(elem_off) -: 8]) begin
          pend_ok = 1'b0;
        end
      end
      default: begin
        if (elem_off == 8'd0) pend_b0 = b;
        else if (elem_off == 8'd3) pend_b3 = b;
        else if (elem_off == 8'd4) pend_b4 = b;
      end
    endcase
  endtask

  // Fold a complete element into the frame summary
  task automatic close_element();
    int unsigned n;
    case (elem_id)
      EID_SSID: begin
        ssid_kept  = (elem_len > SSID_MAX) ? SSID_MAX[5:0] : elem_len[5:0];
        ssid_clean = pend_ok;
      end
      EID_RATES, EID_EXT_RATES: begin
        if (pend_lmax > top_rate) top_rate = pend_lmax;
        n = rate_count + pend_count;
        rate_count = (n > ENTRY_MAX) ? ENTRY_MAX : n;
      end
      EID_DS: chan_num = pend_b0;
      EID_RSN: sec_class = ENC_WPA2;
      EID_VENDOR: begin
        if (elem_len >= VENDOR_MIN_LEN && pend_ok) sec_class = ENC_WPA;
      end
      EID_HT: begin
        if (elem_len >= HT_MIN_LEN) begin
          add_ht_rates(pend_b3, HT_STEP_ONE, pend_b0[1]);
          add_ht_rates(pend_b4, HT_STEP_TWO, pend_b0[1]);
        end
      end
      EID_VHT: begin
        if (elem_len >= VHT_MIN_LEN) begin
          if (pend_b0[2]) begin
            note_rate(VHT_R292);
            note_rate(VHT_R433);
            if ((pend_b4 & VHT_NSS_MASK) != VHT_NSS_MASK) begin
              note_rate(VHT_R585);
              note_rate(VHT_R866);
            end
          end
          if (pend_b0[3]) begin
            note_rate(VHT_R866);
            note_rate(VHT_R1733);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic parse_frame_byte(input logic [7:0] b, input logic lst);
    int unsigned p;
    frame_summary_t s;
    p = byte_pos;
    if (walk_phase == PH_HEADER) begin
      if (p == POS_FRAME_CTRL) beacon_seen = ((b & FC_TYPE_MASK) == FC_BEACON);
      if (p == POS_CAP_LOW) privacy_bit = b[4];
      if (p == POS_HDR_END) walk_phase = PH_TAG;
    end else if (!walk_done) begin
      case (walk_phase)
        PH_TAG: begin
          elem_id    = b;
          walk_phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          // Stop on a zero length or an element running past the window
          if (b == 8'd0 || p + 1 + b > WINDOW_BYTES) begin
            walk_done = 1'b1;
          end else begin
            elem_len = b;
            elem_off = '0;
            clear_pending();
            pend_ok    = 1'b1;
            walk_phase = PH_DATA;
          end
        end
        default: begin
          take_element_byte(b);
          elem_off++;
          if (elem_off == elem_len) begin
            close_element();
            walk_phase = PH_TAG;
          end
        end
      endcase
      if (p + 1 >= WINDOW_BYTES) walk_done = 1'b1;
    end
    if (byte_pos < POS_MAX) byte_pos++;

    if (lst) begin
      s = '0;
      if (beacon_seen) begin
        s.beacon   = 1'b1;
        s.enc      = (sec_class != ENC_OPEN) ? sec_class : (privacy_bit ? ENC_WEP : ENC_OPEN);
        s.chan     = chan_num;
        s.rate     = 11'(((top_rate + 2) / 5) * 5);
        s.ssid_len = ssid_kept;
        s.ssid_ok  = ssid_clean;
      end
      summary_q.push_back(s);
      clear_frame();
    end
  endtask

  // Sample both channels at the edge; inputs before outputs
  always @(posedge clk) begin
    frame_summary_t got;
    frame_summary_t want;
    if (!rst_n) begin
      clear_frame();
      summary_q.delete();
      fail_count      = 0;
      results_checked = 0;
    end else begin
      if (in_valid && !in_stall) parse_frame_byte(in_frame_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        got.beacon   = out_is_beacon;
        got.enc      = out_enc_mode;
        got.chan     = out_channel;
        got.rate     = out_max_rate_mbps;
        got.ssid_len = out_ssid_length;
        got.ssid_ok  = out_ssid_printable;
        if (summary_q.size() == 0) begin
          report_mismatch("result transfer with no frame pending", 11'd1, 11'd0);
        end else begin
          want = summary_q.pop_front();
          results_checked++;
          if (got.beacon !== want.beacon)
            report_mismatch("is_beacon", got.beacon, want.beacon);
          if (got.enc !== want.enc)
            report_mismatch("enc_mode", got.enc, want.enc);
          if (got.chan !== want.chan)
            report_mismatch("channel", got.chan, want.chan);
          if (got.rate !== want.rate)
            report_mismatch("max_rate_mbps", got.rate, want.rate);
          if (got.ssid_len !== want.ssid_len)
            report_mismatch("ssid_length", got.ssid_len, want.ssid_len);
          if (got.ssid_ok !== want.ssid_ok)
            report_mismatch("ssid_printable", got.ssid_ok, want.ssid_ok);
        end
      end
    end
    pending_results = summary_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
  import bep_pkg::*;
;

  localparam int     WINDOW        = 1024;
  localparam int     LEGACY_CAP    = 16;
  localparam int     RESET_CYCLES  = 11;
  localparam int     RANDOM_FRAMES = 48;
  localparam int     RANDOM_BYTES  = 800;
  localparam int     PHASE_B_FRAME = 16;
  localparam int     PHASE_C_FRAME = 32;
  localparam int     BURST_FRAMES  = 24;
  localparam int     HOLD_CYCLES   = 200;
  localparam int     DRAIN_CYCLES  = 10;
  localparam int     LONG_FRAME    = 2100;
  localparam longint RUN_LIMIT_NS  = 64'd10_000_000;

  localparam logic [31:0] WPA_TAG     = 32'h0050F201;
  localparam logic [7:0]  ELEM_FILLER = 8'd7;
  localparam logic [7:0]  FC_PROBE    = 8'h84;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [7:0]  in_frame_byte = '0;
  logic        in_last_byte  = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic        out_is_beacon;
  logic [1:0]  out_enc_mode;
  logic [7:0]  out_channel;
  logic [10:0] out_max_rate_mbps;
  logic [5:0]  out_ssid_length;
  logic        out_ssid_printable;

  int mismatches;
  int pending_results;
  int results_checked;

  // Stimulus state
  logic [7:0] frame_bytes[$];
  int         elem_at;
  int         tx_idle_pct  = 0;
  int         rx_idle_pct  = 0;
  int         frames_sent  = 0;
  int         bytes_sent   = 0;
  logic       hold_req     = 1'b0;
  logic       hold_done    = 1'b0;
  int         hold_left    = 0;

  beacon_element_parser_unit #(
    .WINDOW_BYTES    (WINDOW),
    .LEGACY_RATE_CAP (LEGACY_CAP)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_frame_byte      (in_frame_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_beacon      (out_is_beacon),
    .out_enc_mode       (out_enc_mode),
    .out_channel        (out_channel),
    .out_max_rate_mbps  (out_max_rate_mbps),
    .out_ssid_length    (out_ssid_length),
    .out_ssid_printable (out_ssid_printable)
  );

  beacon_summary_checker #(
    .WINDOW_BYTES    (WINDOW),
    .LEGACY_RATE_CAP (LEGACY_CAP)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_frame_byte      (in_frame_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_beacon      (out_is_beacon),
    .out_enc_mode       (out_enc_mode),
    .out_channel        (out_channel),
    .out_max_rate_mbps  (out_max_rate_mbps),
    .out_ssid_length    (out_ssid_length),
    .out_ssid_printable (out_ssid_printable),
    .fail_count         (mismatches),
    .pending_results    (pending_results),
    .results_checked    (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: one long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Offer one byte, idling at random first; hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_frame_byte <= b;
    in_last_byte  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the first n bytes of the built frame, the last one flagged
  task automatic send_frame(input int n);
    for (int k = 0; k < n; k++) send_byte(frame_bytes[k], k == n - 1);
    frames_sent++;
  endtask

  // Frame control, random header, capability byte with the privacy bit
  task automatic start_frame(input logic [7:0] fc, input logic priv);
    logic [7:0] cap;
    frame_bytes.delete();
    frame_bytes.push_back(fc);
    repeat (POS_CAP_LOW - 1) frame_bytes.push_back(8'($urandom));
    cap    = 8'($urandom);
    cap[4] = priv;
    frame_bytes.push_back(cap);
    frame_bytes.push_back(8'($urandom));
  endtask

  // Tag, length and random body; elem_at points at the first body byte
  task automatic push_element(input logic [7:0] id, input int len);
    frame_bytes.push_back(id);
    frame_bytes.push_back(8'(len));
    elem_at = frame_bytes.size();
    repeat (len) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic set_printable(input int n);
    for (int k = 0; k < n; k++) begin
      frame_bytes[elem_at + k] = 8'($urandom_range(PRINT_HIGH, PRINT_LOW));
    end
  endtask

  task automatic set_wpa_tag(input int n);
    for (int k = 0; k < n && k < 4; k++) begin
      frame_bytes[elem_at + k] = WPA_TAG[31 - 8 * k -: 8];
    end
  endtask

  // Pad with unknown elements so that the next tag lands at byte upto
  task automatic fill_to(input int upto);
    int rem;
    while (frame_bytes.size() < upto) begin
      rem = upto - frame_bytes.size();
      if (rem > 259) push_element(ELEM_FILLER, 255);
      else if (rem > 257) push_element(ELEM_FILLER, 100);
      else push_element(ELEM_FILLER, rem - 2);
    end
  endtask

  task automatic add_random_element();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 15) begin
      len = $urandom_range(40, 1);
      push_element(EID_SSID, len);
      if ($urandom_range(3) != 0) set_printable(len);
    end else if (pick < 30) begin
      push_element($urandom_range(1) ? EID_RATES : EID_EXT_RATES, $urandom_range(14, 1));
    end else if (pick < 40) begin
      push_element(EID_DS, ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 1);
    end else if (pick < 47) begin
      push_element(EID_RSN, $urandom_range(20, 1));
    end else if (pick < 57) begin
      len = $urandom_range(10, 1);
      push_element(EID_VENDOR, len);
      if ($urandom_range(3) != 0) set_wpa_tag(len);
    end else if (pick < 70) begin
      push_element(EID_HT, ($urandom_range(3) != 0) ? 26 : $urandom_range(30, 20));
    end else if (pick < 80) begin
      push_element(EID_VHT, ($urandom_range(3) != 0) ? 12 : $urandom_range(16, 8));
    end else if (pick < 97) begin
      push_element(8'($urandom), $urandom_range(20, 1));
    end else begin
      push_element(8'($urandom), 0);
    end
  endtask

  // Mostly well-formed beacons; some cut short, truncated or non-beacon
  task automatic make_random_frame(output int n);
    logic [7:0] fc;
    fc = ($urandom_range(4) != 0) ? (FC_BEACON | 8'($urandom_range(3))) : 8'($urandom);
    start_frame(fc, 1'($urandom_range(1)));
    repeat ($urandom_range(8)) add_random_element();
    n = frame_bytes.size();
    case ($urandom_range(19))
      0, 1: n = $urandom_range(POS_HDR_END + 1, 1);
      2, 3: if (n > POS_HDR_END + 2) n = $urandom_range(n - 1, POS_HDR_END + 2);
      4: begin
        frame_bytes.push_back(8'($urandom));
        n = frame_bytes.size();
      end
      default: ;
    endcase
  endtask

  initial begin
    int n;
    int random_start;
    tx_idle_pct = 15;
    rx_idle_pct <= 67;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Non-beacon frame with elements: everything reads zero
    start_frame(FC_PROBE, 1'b1);
    push_element(EID_SSID, 6);
    push_element(EID_DS, 1);
    push_element(EID_RSN, 4);
    send_frame(frame_bytes.size());

    // Header only, privacy set: WEP and no SSID
    start_frame(FC_BEACON, 1'b1);
    send_frame(frame_bytes.size());

    // Full SSID, top channel, legacy and extended rates
    start_frame(FC_BEACON | 8'h03, 1'b0);
    push_element(EID_SSID, 32);
    set_printable(32);
    push_element(EID_DS, 1);
    frame_bytes[elem_at] = 8'hFF;
    push_element(EID_RATES, 8);
    frame_bytes[elem_at + 3] = 8'hFF;
    push_element(EID_EXT_RATES, 4);
    send_frame(frame_bytes.size());

    // Repeated SSID: last wins; long one clipped, bad bytes past the clip ignored
    start_frame(FC_BEACON, 1'b0);
    push_element(EID_SSID, 5);
    frame_bytes[elem_at] = PRINT_LOW - 8'd1;
    push_element(EID_SSID, 40);
    set_printable(40);
    frame_bytes[elem_at]      = PRINT_LOW;
    frame_bytes[elem_at + 31] = PRINT_HIGH;
    frame_bytes[elem_at + 33] = PRINT_HIGH + 8'd1;
    frame_bytes[elem_at + 39] = 8'h00;
    send_frame(frame_bytes.size());

    // Non-printable byte at the last kept position
    start_frame(FC_BEACON, 1'b0);
    push_element(EID_SSID, 32);
    set_printable(32);
    frame_bytes[elem_at + 31] = PRINT_HIGH + 8'd1;
    send_frame(frame_bytes.size());

    // WPA then RSN: WPA2 wins over WPA and privacy
    start_frame(FC_BEACON, 1'b1);
    push_element(EID_VENDOR, 4);
    set_wpa_tag(4);
    push_element(EID_RSN, 2);
    send_frame(frame_bytes.size());

    // RSN then WPA; wrong OUI type and short vendor elements change nothing
    start_frame(FC_BEACON, 1'b0);
    push_element(EID_RSN, 20);
    push_element(EID_VENDOR, 8);
    set_wpa_tag(8);
    push_element(EID_VENDOR, 4);
    set_wpa_tag(4);
    frame_bytes[elem_at + 3] = 8'h02;
    push_element(EID_VENDOR, 3);
    set_wpa_tag(3);
    send_frame(frame_bytes.size());

    // Legacy cap: only the first sixteen rate entries count
    start_frame(FC_BEACON, 1'b0);
    push_element(EID_RATES, 20);
    for (int k = 0; k < 20; k++) frame_bytes[elem_at + k] = (k < 16) ? 8'h14 : 8'hFF;
    push_element(EID_EXT_RATES, 2);
    frame_bytes[elem_at]     = 8'hFF;
    frame_bytes[elem_at + 1] = 8'hFF;
    send_frame(frame_bytes.size());

    // Full HT twice at 40 MHz saturates the entry count
    start_frame(FC_BEACON, 1'b0);
    repeat (2) begin
      push_element(EID_HT, 26);
      frame_bytes[elem_at]     = 8'h02;
      frame_bytes[elem_at + 3] = 8'hFF;
      frame_bytes[elem_at + 4] = 8'hFF;
    end
    push_element(EID_RATES, 2);
    frame_bytes[elem_at] = 8'hFF;
    send_frame(frame_bytes.size());

    // VHT top rate, then a lower VHT element
    start_frame(FC_BEACON, 1'b0);
    push_element(EID_VHT, 12);
    frame_bytes[elem_at]     = 8'h0C;
    frame_bytes[elem_at + 4] = VHT_NSS_MASK;
    push_element(EID_VHT, 12);
    frame_bytes[elem_at]     = 8'h04;
    frame_bytes[elem_at + 4] = 8'h00;
    send_frame(frame_bytes.size());

    // HT and VHT one byte short are ignored; narrow HT lowest rate
    start_frame(FC_BEACON, 1'b0);
    push_element(EID_HT, HT_MIN_LEN - 1);
    frame_bytes[elem_at + 3] = 8'hFF;
    push_element(EID_VHT, VHT_MIN_LEN - 1);
    frame_bytes[elem_at] = 8'h0C;
    push_element(EID_HT, 26);
    frame_bytes[elem_at]     = 8'h00;
    frame_bytes[elem_at + 3] = 8'h01;
    frame_bytes[elem_at + 4] = 8'h00;
    send_frame(frame_bytes.size());

    // Zero length stops the walk before the channel element
    start_frame(FC_BEACON, 1'b0);
    push_element(EID_SSID, 8);
    set_printable(8);
    push_element(EID_DS, 0);
    push_element(EID_DS, 1);
    send_frame(frame_bytes.size());

    // SSID cut by the frame end has no effect
    start_frame(FC_BEACON, 1'b0);
    push_element(EID_DS, 1);
    frame_bytes[elem_at] = 8'd1;
    push_element(EID_SSID, 10);
    send_frame(frame_bytes.size() - 5);

    // Short frames: one byte, and ending before the walk starts
    start_frame(FC_BEACON, 1'b1);
    send_frame(1);
    start_frame(FC_BEACON, 1'b1);
    send_frame(POS_HDR_END);

    // Last element ends on the final window byte
    start_frame(FC_BEACON, 1'b0);
    push_element(EID_DS, 1);
    frame_bytes[elem_at] = 8'd6;
    fill_to(WINDOW - 3);
    push_element(EID_DS, 1);
    frame_bytes[elem_at] = 8'd11;
    push_element(EID_DS, 1);
    repeat (10) frame_bytes.push_back(8'($urandom));
    send_frame(frame_bytes.size());

    // Element one byte past the window stops the walk
    start_frame(FC_BEACON, 1'b0);
    push_element(EID_DS, 1);
    frame_bytes[elem_at] = 8'd6;
    fill_to(WINDOW - 2);
    push_element(EID_DS, 1);
    frame_bytes[elem_at] = 8'd11;
    send_frame(frame_bytes.size());

    // Long frame: position saturates
    start_frame(FC_BEACON, 1'b1);
    push_element(EID_SSID, 12);
    set_printable(12);
    while (frame_bytes.size() < LONG_FRAME) frame_bytes.push_back(8'($urandom));
    send_frame(frame_bytes.size());

    // Random frames over three idle profiles
    random_start = bytes_sent;
    for (int f = 0; f < RANDOM_FRAMES || bytes_sent - random_start < RANDOM_BYTES; f++) begin
      if (f == PHASE_B_FRAME) begin
        tx_idle_pct = 67;
        rx_idle_pct <= 15;
      end
      if (f == PHASE_C_FRAME) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req    <= 1'b1;
        // Short frames pile up behind the held result side
        repeat (BURST_FRAMES) begin
          start_frame(($urandom_range(1) != 0) ? FC_BEACON : 8'($urandom), 1'($urandom));
          send_frame($urandom_range(4, 1));
        end
      end
      make_random_frame(n);
      send_frame(n);
    end
    in_valid <= 1'b0;

    // Drain
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d frames (%0d byte transfers, %0d summaries compared): header, element,",
             frames_sent, bytes_sent, results_checked);
    $display("window-edge and long-frame cases under idle gaps and result back-pressure.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
